>>> src/bpl_pkg.sv
package bpl_pkg;

	localparam int LIMITERS_PER_BANK = 16;

	localparam int IDX_W   = 4;
	localparam int SEC_W   = 32;
	localparam int USEC_W  = 20;
	localparam int BYTES_W = 32;
	localparam int RATE_W  = 32;
	localparam int TIME_W  = 32;
	localparam int MS_W    = 23;

	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 24;

	localparam logic [TIME_W-1:0]  MAX_AGE_S     = 32'd120;
	localparam logic [TIME_W-1:0]  MICROS_PER_S  = 32'd1000000;
	localparam logic [BYTES_W-1:0] SMALL_LIMIT   = 32'd512;
	localparam logic [BYTES_W-1:0] HALF_CHUNK    = 32'd32;
	localparam int                 CHUNK_SHIFT   = 6;
	localparam logic [TIME_W-1:0]  CHUNK_BITS_US = 32'd512000000;
	localparam logic [TIME_W-1:0]  BYTE_BITS_US  = 32'd8000000;

	localparam int DIVIDEND_W = 56;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STEPS  = DIVIDEND_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam int                MS_MAGIC_W = 29;
	localparam logic [28:0]       MS_MAGIC   = 29'd274877907;
	localparam int                MS_SHIFT   = 38;
	localparam int                SCALE_W    = TIME_W + MS_MAGIC_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_CALC,
		S_DIV,
		S_MULT,
		S_WRITE,
		S_SCALE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic div_start;
		logic tx_calc;
		logic write;
		logic scale;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic fresh;
		logic last;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

>>> src/bpl_divider.sv
module bpl_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [bpl_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [bpl_pkg::RATE_W-1:0]      divisor,
	output logic                            done,
	output logic [bpl_pkg::TIME_W-1:0]      quotient
);

	logic [bpl_pkg::DIVIDEND_W-1:0] dvd_q;
	logic [bpl_pkg::RATE_W-1:0]     dsr_q;
	logic [bpl_pkg::RATE_W-1:0]     rem_q;
	logic [bpl_pkg::TIME_W-1:0]     quo_q;
	logic [bpl_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [bpl_pkg::DIVIDEND_W-1:0] dvd_d;
	logic [bpl_pkg::RATE_W-1:0]     rem_d;
	logic [bpl_pkg::TIME_W-1:0]     quo_d;

	always_comb begin
		logic [bpl_pkg::DIVIDEND_W-1:0] d;
		logic [bpl_pkg::RATE_W-1:0]     r;
		logic [bpl_pkg::TIME_W-1:0]     q;
		logic [bpl_pkg::RATE_W:0]       t;
		d = dvd_q;
		r = rem_q;
		q = quo_q;
		t = '0;
		for (int k = 0; k < bpl_pkg::DIV_BITS; k++) begin
			t = {r, d[bpl_pkg::DIVIDEND_W-1]};
			d = {d[bpl_pkg::DIVIDEND_W-2:0], 1'b0};
			if (t >= {1'b0, dsr_q}) begin
				t = t - {1'b0, dsr_q};
				q = {q[bpl_pkg::TIME_W-2:0], 1'b1};
			end else begin
				q = {q[bpl_pkg::TIME_W-2:0], 1'b0};
			end
			r = t[bpl_pkg::RATE_W-1:0];
		end
		dvd_d = d;
		rem_d = r;
		quo_d = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == bpl_pkg::DIV_CNT_W'(bpl_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + bpl_pkg::DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> src/bpl_datapath.sv
module bpl_datapath #(
	parameter int LIMITERS_PER_BANK = bpl_pkg::LIMITERS_PER_BANK
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bpl_pkg::cmd_t                    cmd,
	output bpl_pkg::status_t                 status,
	input  logic [bpl_pkg::IN_TDATA_W-1:0]   in_data,
	input  logic                             in_dir,
	input  logic                             in_last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bpl_pkg::OUT_TDATA_W-1:0]  out_data
);

	localparam int USED     = (LIMITERS_PER_BANK < (1 << bpl_pkg::IDX_W)) ?
	                          LIMITERS_PER_BANK : (1 << bpl_pkg::IDX_W);
	localparam int ENTRIES  = 2 * USED;
	localparam int ENTRY_AW = $clog2(ENTRIES);

	logic [bpl_pkg::IDX_W-1:0]   idx_q;
	logic                        dir_q;
	logic [bpl_pkg::SEC_W-1:0]   sec_q;
	logic [bpl_pkg::USEC_W-1:0]  usec_q;
	logic [bpl_pkg::BYTES_W-1:0] bytes_q;
	logic [bpl_pkg::RATE_W-1:0]  rate_q;
	logic                        last_q;

	logic [bpl_pkg::SEC_W-1:0]  base_mem_q [ENTRIES];
	logic [bpl_pkg::TIME_W-1:0] next_mem_q [ENTRIES];

	logic                           fresh_q;
	logic                           big_out_q;
	logic [bpl_pkg::TIME_W-1:0]     offset_q;
	logic [bpl_pkg::TIME_W-1:0]     stored_next_q;
	logic [bpl_pkg::DIVIDEND_W-1:0] dividend_q;
	logic [bpl_pkg::RATE_W-1:0]     divisor_q;
	logic [bpl_pkg::TIME_W-1:0]     wait_q;
	logic [bpl_pkg::TIME_W-1:0]     tx_q;
	logic [bpl_pkg::TIME_W-1:0]     longest_q;
	logic [bpl_pkg::SCALE_W-1:0]    scaled_q;
	logic [bpl_pkg::MS_W-1:0]       sleep_q;
	logic                           out_valid_q;

	logic [ENTRY_AW-1:0]            entry_addr;
	logic                           in_range;
	logic [bpl_pkg::SEC_W-1:0]      rd_base;
	logic [bpl_pkg::SEC_W-1:0]      age;
	logic                           fresh;
	logic [bpl_pkg::TIME_W-1:0]     offset_d;
	logic [bpl_pkg::BYTES_W-1:0]    factor;
	logic [bpl_pkg::DIVIDEND_W-1:0] product;
	logic                           big_out;
	logic [bpl_pkg::BYTES_W-1:0]    chunk_sum;
	logic [bpl_pkg::TIME_W-1:0]     chunks;
	logic                           div_done;
	logic [bpl_pkg::TIME_W-1:0]     quotient;

	assign in_range   = 32'(idx_q) < 32'(LIMITERS_PER_BANK);
	assign entry_addr = dir_q ? ENTRY_AW'(USED) + ENTRY_AW'(idx_q) : ENTRY_AW'(idx_q);
	assign rd_base    = base_mem_q[entry_addr];
	assign age        = sec_q - rd_base;
	assign fresh      = (rd_base == '0) || (rd_base > sec_q) || (age > bpl_pkg::MAX_AGE_S);
	assign offset_d   = bpl_pkg::TIME_W'(age[6:0]) * bpl_pkg::MICROS_PER_S + {12'd0, usec_q};
	assign factor     = dir_q ? bytes_q + 32'd1 : bytes_q;
	assign product    = bpl_pkg::DIVIDEND_W'(factor) *
	                    bpl_pkg::DIVIDEND_W'(bpl_pkg::BYTE_BITS_US);
	assign big_out    = dir_q && (bytes_q > bpl_pkg::SMALL_LIMIT);
	assign chunk_sum  = bytes_q + bpl_pkg::HALF_CHUNK;
	assign chunks     = chunk_sum >> bpl_pkg::CHUNK_SHIFT;

	bpl_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q   <= in_data[3:0];
			sec_q   <= in_data[35:4];
			usec_q  <= in_data[55:36];
			bytes_q <= in_data[87:56];
			rate_q  <= in_data[119:88];
			dir_q   <= in_dir;
			last_q  <= in_last;
		end
		if (cmd.eval) begin
			fresh_q       <= fresh;
			big_out_q     <= big_out;
			offset_q      <= offset_d;
			stored_next_q <= next_mem_q[entry_addr];
			dividend_q    <= big_out ? bpl_pkg::DIVIDEND_W'(bpl_pkg::CHUNK_BITS_US) : product;
			divisor_q     <= (rate_q == '0) ? 32'd1 : rate_q;
		end
		if (cmd.div_start) begin
			wait_q <= (stored_next_q > offset_q) ? stored_next_q - offset_q : '0;
		end
		if (cmd.tx_calc) begin
			tx_q <= big_out_q ? quotient * chunks : quotient;
		end
		if (cmd.scale) begin
			scaled_q <= bpl_pkg::SCALE_W'(longest_q) * bpl_pkg::SCALE_W'(bpl_pkg::MS_MAGIC);
		end
		if (cmd.emit) begin
			sleep_q <= scaled_q[bpl_pkg::MS_SHIFT +: bpl_pkg::MS_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				base_mem_q[i] <= '0;
				next_mem_q[i] <= '0;
			end
			longest_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.write) begin
				base_mem_q[entry_addr] <= sec_q;
				next_mem_q[entry_addr] <= fresh_q ? '0 : {12'd0, usec_q} + wait_q + tx_q;
				if (!fresh_q && (wait_q > longest_q)) begin
					longest_q <= wait_q;
				end
			end
			if (cmd.scale) begin
				longest_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.skip     = (bytes_q == '0) || !in_range;
	assign status.fresh    = fresh;
	assign status.last     = last_q;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {1'b0, sleep_q};

endmodule

>>> src/bpl_ctrl.sv
module bpl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bpl_pkg::status_t  status,
	output bpl_pkg::cmd_t     cmd
);

	bpl_pkg::state_t state_q;
	bpl_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpl_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = bpl_pkg::S_EVAL;
				end
			end
			bpl_pkg::S_EVAL: begin
				if (status.skip) begin
					state_d = status.last ? bpl_pkg::S_SCALE : bpl_pkg::S_IDLE;
				end else if (status.fresh) begin
					state_d = bpl_pkg::S_WRITE;
				end else begin
					state_d = bpl_pkg::S_CALC;
				end
			end
			bpl_pkg::S_CALC: begin
				state_d = bpl_pkg::S_DIV;
			end
			bpl_pkg::S_DIV: begin
				if (status.div_done) begin
					state_d = bpl_pkg::S_MULT;
				end
			end
			bpl_pkg::S_MULT: begin
				state_d = bpl_pkg::S_WRITE;
			end
			bpl_pkg::S_WRITE: begin
				state_d = status.last ? bpl_pkg::S_SCALE : bpl_pkg::S_IDLE;
			end
			bpl_pkg::S_SCALE: begin
				state_d = bpl_pkg::S_EMIT;
			end
			bpl_pkg::S_EMIT: begin
				if (status.out_free) begin
					state_d = bpl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpl_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			bpl_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			bpl_pkg::S_EVAL: begin
				cmd.eval = 1'b1;
			end
			bpl_pkg::S_CALC: begin
				cmd.div_start = 1'b1;
			end
			bpl_pkg::S_DIV: begin
			end
			bpl_pkg::S_MULT: begin
				cmd.tx_calc = 1'b1;
			end
			bpl_pkg::S_WRITE: begin
				cmd.write = 1'b1;
			end
			bpl_pkg::S_SCALE: begin
				cmd.scale = 1'b1;
			end
			bpl_pkg::S_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> src/bandwidth_pacing_limiter.sv
// Channel   Side     Payload
// s_axis    input    tdata: limiter_index, now_seconds, now_micros, byte_count, rate_bps;
//                    tuser: direction; tlast: last_limiter
// m_axis    output   tdata: sleep_ms
//
// A live entry passes through capture, evaluation, divider start, the serial divider,
// which retires two quotient bits per cycle until it reports done, the multiply and
// the write. A fresh entry goes from evaluation to the write, and a beat that touches
// no entry ends after evaluation. A last beat adds the scale and emit steps.
// Reset clears all limiter entries, the longest wait and the output valid flag.
// A result waits in the output register; s_tready returns while it waits, and only
// the next last beat stalls until the register is free.
module bandwidth_pacing_limiter #(
	parameter int LIMITERS_PER_BANK = bpl_pkg::LIMITERS_PER_BANK
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// limiter_index, now_seconds, now_micros, byte_count, rate_bps
	input  logic [bpl_pkg::IN_TDATA_W-1:0]   s_tdata,
	// direction
	input  logic                             s_tuser,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// sleep_ms
	output logic [bpl_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	bpl_pkg::cmd_t    cmd;
	bpl_pkg::status_t status;

	bpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bpl_datapath #(
		.LIMITERS_PER_BANK (LIMITERS_PER_BANK)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.in_dir    (s_tuser),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
